FILE: rtl/video_display_port_interface_top_assert.svh
// Assertion macros for the video display port interface.
// They are used at the end of the top level and need clk and rst in scope.
`ifndef VIDEO_DISPLAY_PORT_INTERFACE_TOP_ASSERT_SVH
`define VIDEO_DISPLAY_PORT_INTERFACE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define VDPI_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vdpi: assertion failed");
`define VDPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vdpi: assertion failed");
`else
`define VDPI_ASSERT_IMPLY(lbl, ante, cons)
`define VDPI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/vdpi_pkg.sv
// Package for the video display port interface: codes, sizes, mask tables.
// Used by vdpi_cfg and the top level; depends on nothing.
package vdpi_pkg;

  localparam int VRAM_DEPTH = 131072;
  localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam logic [16:0] VRAM_DEPTH_MASK = 17'(VRAM_DEPTH - 1);

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PORT_DATA     = 2'd0,
    PORT_CTRL     = 2'd1,
    PORT_PALETTE  = 2'd2,
    PORT_INDIRECT = 2'd3
  } port_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_CTRL    = 2'd1,
    EV_PALETTE = 2'd2,
    EV_VRAM    = 2'd3
  } event_e;

  localparam logic [1:0] VER_GEN2_PLUS = 2'd3;
  localparam logic [1:0] SIZE_16K      = 2'd0;
  localparam logic [1:0] SIZE_64K      = 2'd1;

  localparam logic [5:0] REG_MODE0   = 6'd0;
  localparam logic [5:0] REG_MODE1   = 6'd1;
  localparam logic [5:0] REG_PAGE    = 6'd14;
  localparam logic [5:0] REG_STAT    = 6'd15;
  localparam logic [5:0] REG_PAL_IDX = 6'd16;
  localparam logic [5:0] REG_IND     = 6'd17;

  localparam logic CFG_VERSION   = 1'b0;
  localparam logic CFG_VRAM_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0] version;
    logic [1:0] vram_size;
    logic       version_wr;
    logic [1:0] version_new;
  } cfg_t;

  function automatic logic is_gen1(input logic [1:0] ver);
    return ~ver[1];
  endfunction

  function automatic logic [7:0] value_mask(input logic [1:0] ver, input logic [5:0] r);
    logic [7:0] m;
    m = 8'h00;
    if (is_gen1(ver)) begin
      case (r)
        6'd0: m = 8'h03;  6'd1: m = 8'hFB;  6'd2: m = 8'h0F;  6'd3: m = 8'hFF;
        6'd4: m = 8'h07;  6'd5: m = 8'h7F;  6'd6: m = 8'h07;  6'd7: m = 8'hFF;
        default: m = 8'h00;
      endcase
    end else begin
      case (r)
        6'd0:  m = 8'h7E; 6'd1:  m = 8'h7B; 6'd2:  m = 8'h7F; 6'd3:  m = 8'hFF;
        6'd4:  m = 8'h3F; 6'd5:  m = 8'hFF; 6'd6:  m = 8'h3F; 6'd7:  m = 8'hFF;
        6'd8:  m = 8'hFB; 6'd9:  m = 8'hBF; 6'd10: m = 8'h07; 6'd11: m = 8'h03;
        6'd12: m = 8'hFF; 6'd13: m = 8'hFF; 6'd14: m = 8'h07; 6'd15: m = 8'h0F;
        6'd16: m = 8'h0F; 6'd17: m = 8'hBF; 6'd18: m = 8'hFF; 6'd19: m = 8'hFF;
        6'd20: m = 8'h3F; 6'd21: m = 8'h3F; 6'd22: m = 8'h3F; 6'd23: m = 8'hFF;
        6'd25: m = (ver == VER_GEN2_PLUS) ? 8'h7F : 8'h00;
        6'd26: m = (ver == VER_GEN2_PLUS) ? 8'h3F : 8'h00;
        6'd27: m = (ver == VER_GEN2_PLUS) ? 8'h07 : 8'h00;
        6'd32: m = 8'hFF; 6'd33: m = 8'h01; 6'd34: m = 8'hFF; 6'd35: m = 8'h03;
        6'd36: m = 8'hFF; 6'd37: m = 8'h01; 6'd38: m = 8'hFF; 6'd39: m = 8'h03;
        6'd40: m = 8'hFF; 6'd41: m = 8'h01; 6'd42: m = 8'hFF; 6'd43: m = 8'h03;
        6'd44: m = 8'hFF; 6'd45: m = 8'h7F; 6'd46: m = 8'hFF;
        default: m = 8'h00;
      endcase
    end
    return m;
  endfunction

  function automatic logic [7:0] status_init(input logic [3:0] i);
    logic [7:0] v;
    case (i)
      4'd2:    v = 8'h6C;
      4'd4:    v = 8'hFE;
      4'd6:    v = 8'hFC;
      4'd9:    v = 8'hFE;
      4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15: v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/vdpi_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
module vdpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/vdpi_cfg.sv
// Configuration register file of the video display port interface (APB port).
// Depends on vdpi_pkg for the register indexes and the cfg_t struct.
module vdpi_cfg import vdpi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [1:0] version;
  logic [1:0] vram_size;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      version   <= 2'd2;
      vram_size <= 2'd2;
    end else if (wr) begin
      if (paddr[2] == CFG_VERSION) begin
        version <= pwdata[1:0];
      end else begin
        vram_size <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == CFG_VRAM_SIZE) begin
      prdata[1:0] = vram_size;
    end else begin
      prdata[1:0] = version;
    end
  end

  // The status block needs the new version at the same edge as the write.
  assign cfg.version     = version;
  assign cfg.vram_size   = vram_size;
  assign cfg.version_wr  = wr & (paddr[2] == CFG_VERSION);
  assign cfg.version_new = pwdata[1:0];

endmodule

FILE: rtl/video_display_port_interface_top.sv
// Top level of the video display port interface: CPU port handling around VRAM.
// Depends on vdpi_pkg, vdpi_ram, vdpi_cfg and the assertion macro header.
//
// Each item has a read step and a retire step: at the accepting edge the VRAM
// and the control register memory are read at the addresses the item needs; when
// the item retires, which waits while the output register is full and stalled,
// the read data is combined with the port state, the result is loaded into the
// output register and the memories are written back. The registered read port
// of the 128K x 8 video RAM is why an item is split; a new item is taken once
// the previous one has moved into the output register, which may itself still
// be waiting to be taken. After reset the block runs a clearing pass that zeroes
// the video RAM one byte a cycle, during which in_stall is high; configuration
// writes are taken throughout. Registers 0, 1 and 14 to 17, which steer the port
// logic, are kept in flip-flops as well as in the register memory; the others are
// read back from the memory, with a valid bit per register standing in for the
// reset value of zero. The palette is write-only from the CPU side, so each
// written word is reported only as an item's change event.
module video_display_port_interface_top import vdpi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [1:0]  port,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        irq,
  output logic [4:0]  display_mode,
  output logic [1:0]  event_kind,
  output logic [16:0] event_addr,
  output logic [15:0] event_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;

  vdpi_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Port state.
  logic [13:0] ptr, ptr_next;
  logic [7:0]  ra, ra_next;
  logic        ctl_full, ctl_full_next;
  logic [7:0]  ctl_byte, ctl_byte_next;
  logic        pal_full, pal_full_next;
  logic [7:0]  pal_byte, pal_byte_next;
  logic        irq_flag, irq_next;
  logic [7:0]  reg0, reg0_next, reg1, reg1_next, reg17, reg17_next;
  logic [2:0]  reg14, reg14_next;
  logic [3:0]  reg15, reg15_next, reg16, reg16_next;
  logic [7:0]  status [16];
  logic [7:0]  status_next [16];
  logic [63:0] creg_valid;

  // Clearing pass.
  logic [VRAM_AW:0] clr_cnt;
  logic             clearing;
  assign clearing = ~clr_cnt[VRAM_AW];

  // Item accepted and waiting to retire.
  logic               busy, accept, retire;
  logic [1:0]         st_req, st_port;
  logic [7:0]         st_data;
  logic [VRAM_AW-1:0] st_vaddr;
  logic [5:0]         st_reg;

  assign in_stall = clearing | busy;
  assign accept   = in_valid & ~in_stall;
  assign retire   = busy & (~out_valid | ~out_stall);

  // Address generation at the accepting edge.
  logic               gen1, addr_set;
  logic [13:0]        ptr_sel;
  logic [16:0]        vmask, full_addr;
  logic [VRAM_AW-1:0] vaddr;
  logic [5:0]         regnum;

  assign gen1     = is_gen1(cfg.version);
  assign addr_set = (req_type == REQ_WRITE) && (port == PORT_CTRL) && ctl_full && !data[7];
  assign ptr_sel  = addr_set ? {data[5:0], ctl_byte} : ptr;

  always_comb begin
    if (gen1 || cfg.vram_size == SIZE_16K) begin
      vmask = 17'h03FFF;
    end else if (cfg.vram_size == SIZE_64K) begin
      vmask = 17'h0FFFF;
    end else begin
      vmask = 17'h1FFFF;
    end
  end

  assign full_addr = {reg14, ptr_sel} & vmask & VRAM_DEPTH_MASK;
  assign vaddr     = full_addr[VRAM_AW-1:0];
  assign regnum    = (port == PORT_INDIRECT) ? reg17[5:0]
                   : (gen1 ? {3'b000, data[2:0]} : data[5:0]);

  // Memories.
  logic               vram_we, vram_op_we;
  logic [VRAM_AW-1:0] vram_waddr;
  logic [7:0]         vram_wdata, vram_rdata;
  logic               creg_we;
  logic [7:0]         creg_rdata, mval;

  assign vram_we    = clearing | (retire & vram_op_we);
  assign vram_waddr = clearing ? clr_cnt[VRAM_AW-1:0] : st_vaddr;
  assign vram_wdata = clearing ? 8'h00 : st_data;

  vdpi_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
    .clk, .we(vram_we), .waddr(vram_waddr), .wdata(vram_wdata),
    .re(accept), .raddr(vaddr), .rdata(vram_rdata)
  );

  vdpi_ram #(.WIDTH(8), .DEPTH(64)) u_creg (
    .clk, .we(retire & creg_we), .waddr(st_reg), .wdata(mval),
    .re(accept), .raddr(regnum), .rdata(creg_rdata)
  );

  // Current display mode, used by the page auto-increment.
  logic [4:0] display_mode_cur;
  assign display_mode_cur = {reg0[3:1], reg1[3], reg1[4]};

  // Retire step: combine read data with the state.
  logic [7:0]  rd, old_val, wr_raw, s2;
  logic [1:0]  evk;
  logic [16:0] eva;
  logic [15:0] evv;
  logic        do_adv, wr_en, inc17, changed;
  logic [13:0] adv_base;
  logic [3:0]  sel;

  always_comb begin
    ptr_next      = ptr;
    ra_next       = ra;
    ctl_full_next = ctl_full;
    ctl_byte_next = ctl_byte;
    pal_full_next = pal_full;
    pal_byte_next = pal_byte;
    irq_next      = irq_flag;
    reg0_next     = reg0;
    reg1_next     = reg1;
    reg14_next    = reg14;
    reg15_next    = reg15;
    reg16_next    = reg16;
    reg17_next    = reg17;
    status_next   = status;
    rd            = 8'h00;
    evk           = EV_NONE;
    eva           = 17'd0;
    evv           = 16'd0;
    vram_op_we    = 1'b0;
    do_adv        = 1'b0;
    adv_base      = ptr;
    wr_en         = 1'b0;
    wr_raw        = 8'h00;
    inc17         = 1'b0;
    creg_we       = 1'b0;
    sel           = reg15;
    s2            = status[2];

    case (st_req)
      REQ_READ: begin
        case (st_port)
          PORT_DATA: begin
            rd            = ra;
            ra_next       = vram_rdata;
            do_adv        = 1'b1;
            ctl_full_next = 1'b0;
          end
          PORT_CTRL: begin
            rd = status[sel];
            if (sel == 4'd0) begin
              status_next[0] = status[0] & 8'h1F;
              irq_next       = 1'b0;
            end else if (sel == 4'd2) begin
              s2 = s2 | 8'h80;
              if (!s2[5]) begin
                s2 = s2 | 8'h20;
              end else begin
                s2 = (s2 & 8'hDF) ^ 8'h40;
              end
              status_next[2] = s2;
            end
            ctl_full_next = 1'b0;
          end
          default: rd = 8'hFF;
        endcase
      end
      REQ_WRITE: begin
        case (st_port)
          PORT_DATA: begin
            vram_op_we    = 1'b1;
            evk           = EV_VRAM;
            eva           = 17'(st_vaddr);
            evv           = {8'h00, st_data};
            do_adv        = 1'b1;
            ra_next       = st_data;
            ctl_full_next = 1'b0;
          end
          PORT_CTRL: begin
            if (!ctl_full) begin
              ctl_full_next = 1'b1;
              ctl_byte_next = st_data;
            end else begin
              if (st_data[7]) begin
                wr_en  = 1'b1;
                wr_raw = ctl_byte;
              end else begin
                ptr_next = {st_data[5:0], ctl_byte};
                if (!st_data[6]) begin
                  ra_next  = vram_rdata;
                  do_adv   = 1'b1;
                  adv_base = {st_data[5:0], ctl_byte};
                end
              end
              ctl_full_next = 1'b0;
            end
          end
          PORT_PALETTE: begin
            if (!gen1) begin
              if (!pal_full) begin
                pal_full_next = 1'b1;
                pal_byte_next = st_data;
              end else begin
                evk           = EV_PALETTE;
                eva           = {13'd0, reg16};
                evv           = {st_data, pal_byte};
                reg16_next    = reg16 + 4'd1;
                pal_full_next = 1'b0;
              end
            end
          end
          default: begin
            if (!gen1) begin
              wr_en  = 1'b1;
              wr_raw = st_data;
              inc17  = ~reg17[7];
            end
          end
        endcase
      end
      REQ_TICK: begin
        status_next[0][7] = 1'b1;
        if (reg1[5]) begin
          irq_next = 1'b1;
        end
      end
      default: ;
    endcase

    // Pointer auto-increment; the page in register 14 follows in the wide modes.
    if (do_adv) begin
      ptr_next = adv_base + 14'd1;
      if (ptr_next == 14'd0 && (display_mode_cur[4] | display_mode_cur[3])) begin
        reg14_next = reg14 + 3'd1;
      end
    end

    // Control register write.
    case (st_reg)
      REG_MODE0:   old_val = reg0;
      REG_MODE1:   old_val = reg1;
      REG_PAGE:    old_val = {5'd0, reg14};
      REG_STAT:    old_val = {4'd0, reg15};
      REG_PAL_IDX: old_val = {4'd0, reg16};
      REG_IND:     old_val = reg17;
      default:     old_val = creg_valid[st_reg] ? creg_rdata : 8'h00;
    endcase
    mval    = wr_raw & value_mask(cfg.version, st_reg);
    changed = wr_en && (mval != old_val);
    if (changed) begin
      creg_we = 1'b1;
      evk     = EV_CTRL;
      eva     = {11'd0, st_reg};
      evv     = {8'h00, mval};
      case (st_reg)
        REG_MODE0:   reg0_next  = mval;
        REG_MODE1:   reg1_next  = mval;
        REG_PAGE:    reg14_next = mval[2:0];
        REG_STAT:    reg15_next = mval[3:0];
        REG_PAL_IDX: reg16_next = mval[3:0];
        REG_IND:     reg17_next = mval;
        default: ;
      endcase
      if (st_reg == REG_MODE1 && mval[5] && status[0][7]) begin
        irq_next = 1'b1;
      end
      if (st_reg == REG_PAL_IDX) begin
        pal_full_next = 1'b0;
      end
    end
    if (inc17) begin
      reg17_next = {2'b00, reg17[5:0] + 6'd1};
    end
    // The version bit of status register 1 tracks every version write.
    if (cfg.version_wr) begin
      status_next[1][2] = (cfg.version_new == VER_GEN2_PLUS);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      ptr        <= 14'd0;
      ra         <= 8'h00;
      ctl_full   <= 1'b0;
      ctl_byte   <= 8'h00;
      pal_full   <= 1'b0;
      pal_byte   <= 8'h00;
      irq_flag   <= 1'b0;
      reg0       <= 8'h00;
      reg1       <= 8'h00;
      reg14      <= 3'd0;
      reg15      <= 4'd0;
      reg16      <= 4'd0;
      reg17      <= 8'h00;
      creg_valid <= 64'd0;
      for (int i = 0; i < 16; i++) begin
        status[i] <= status_init(4'(i));
      end
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + (VRAM_AW+1)'(1);
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (retire) begin
        busy <= 1'b0;
      end
      if (retire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (retire) begin
        ptr      <= ptr_next;
        ra       <= ra_next;
        ctl_full <= ctl_full_next;
        ctl_byte <= ctl_byte_next;
        pal_full <= pal_full_next;
        pal_byte <= pal_byte_next;
        irq_flag <= irq_next;
        reg0     <= reg0_next;
        reg1     <= reg1_next;
        reg14    <= reg14_next;
        reg15    <= reg15_next;
        reg16    <= reg16_next;
        reg17    <= reg17_next;
        status   <= status_next;
        if (changed) begin
          creg_valid[st_reg] <= 1'b1;
        end
      end else if (cfg.version_wr) begin
        status[1][2] <= (cfg.version_new == VER_GEN2_PLUS);
      end
    end
  end

  // Item payload and result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      st_req   <= req_type;
      st_port  <= port;
      st_data  <= data;
      st_vaddr <= vaddr;
      st_reg   <= regnum;
    end
    if (retire) begin
      read_data    <= rd;
      irq          <= irq_next;
      display_mode <= {reg0_next[3:1], reg1_next[3], reg1_next[4]};
      event_kind   <= evk;
      event_addr   <= eva;
      event_value  <= evv;
    end
  end

`include "video_display_port_interface_top_assert.svh"

  `VDPI_ASSERT_IMPLY(a_no_item_while_clearing, in_valid && !in_stall, !clearing)
  `VDPI_ASSERT_NEXT(a_retire_loads_result, retire, out_valid && !busy)
  `VDPI_ASSERT_IMPLY(a_empty_event, out_valid && event_kind == EV_NONE, event_addr == 17'd0 && event_value == 16'd0)
  `VDPI_ASSERT_IMPLY(a_no_vram_write_idle, vram_we && !clearing, retire && st_req == REQ_WRITE)

endmodule
